[rtl/gdft_pkg.sv]
package gdft_pkg;

  typedef enum logic [1:0] {
    OP_VERTEX   = 2'd0,
    OP_EDGE     = 2'd1,
    OP_TRAVERSE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_A,
    ST_EDGE_RD,
    ST_EDGE_B,
    ST_CLEAR,
    ST_ROOT,
    ST_ROOT_RD,
    ST_ROOT_EMIT,
    ST_TOP_RD,
    ST_NODE_RD,
    ST_NODE_CHK,
    ST_NB_EMIT,
    ST_FLUSH
  } state_t;

  localparam logic [7:0] NIL = 8'hFF;

endpackage

[rtl/graph_depth_first_traversal.sv]
// Depth-first traversal of an undirected graph. A vertex item writes its label
// and an empty list head when accepted, and an edge item reads and then writes
// the single-port list head memory once per endpoint. A traverse item first
// clears the visited marks, then tries each vertex index in turn as a root,
// starting a walk from each unmarked one, walking its list nodes and popping
// each vertex whose list runs out, and then finishes. Results appear one cycle
// each with out_valid high and cannot be held off; out_last flags the final
// one, which appears in the cycle in which busy falls.
module graph_depth_first_traversal #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_op,
  input  logic [7:0] in_vertex_label,
  input  logic [5:0] in_vertex_a,
  input  logic [5:0] in_vertex_b,
  output logic       out_valid,
  output logic [5:0] out_visited_index,
  output logic [7:0] out_visited_label,
  output logic       out_last
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NODE_CAP = 2 * MAX_EDGES;
  localparam int NW = $clog2(NODE_CAP);

  logic [7:0]  label_mem [MAX_VERTICES];
  logic [7:0]  head_mem  [MAX_VERTICES];
  logic [13:0] node_mem  [NODE_CAP];
  logic [13:0] stack_mem [MAX_VERTICES];
  logic        mark_mem  [MAX_VERTICES];

  gdft_pkg::state_t state_r, state_nxt;
  logic [6:0] vcount_r;
  logic [7:0] ncount_r;
  logic [5:0] ea_r, eb_r;
  logic [6:0] root_r;
  logic [6:0] sp_r;
  logic [6:0] nout_r;
  logic [6:0] clr_r;
  logic [5:0] cur_v_r, nb_r;
  logic [7:0] label_q, head_q;
  logic [13:0] node_q, stack_q;
  logic       mark_q;
  logic       pend_r;
  logic [5:0] pend_idx_r;
  logic [7:0] pend_lbl_r;
  logic       ov_r, ol_r;
  logic [5:0] oi_r;
  logic [7:0] olb_r;

  logic accept;
  logic take_nb;
  logic emit_pend;
  logic [VW-1:0] head_ra;
  logic [VW-1:0] sp_top;

  assign accept = start && !busy;
  assign busy = (state_r != gdft_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdft_pkg::ST_IDLE: begin
        if (accept) begin
          case (gdft_pkg::op_t'(in_op))
            gdft_pkg::OP_EDGE: begin
              if ({1'b0, in_vertex_a} < vcount_r && {1'b0, in_vertex_b} < vcount_r &&
                  ({1'b0, ncount_r} + 9'd2) <= 9'(NODE_CAP))
                state_nxt = gdft_pkg::ST_EDGE_A;
            end
            gdft_pkg::OP_TRAVERSE: state_nxt = gdft_pkg::ST_CLEAR;
            default: state_nxt = gdft_pkg::ST_IDLE;
          endcase
        end
      end
      gdft_pkg::ST_EDGE_A: state_nxt = gdft_pkg::ST_EDGE_RD;
      gdft_pkg::ST_EDGE_RD: state_nxt = gdft_pkg::ST_EDGE_B;
      gdft_pkg::ST_EDGE_B: state_nxt = gdft_pkg::ST_IDLE;
      gdft_pkg::ST_CLEAR:
        if (clr_r == 7'(MAX_VERTICES - 1)) state_nxt = gdft_pkg::ST_ROOT;
      gdft_pkg::ST_ROOT:
        state_nxt = (root_r < vcount_r) ? gdft_pkg::ST_ROOT_RD : gdft_pkg::ST_FLUSH;
      gdft_pkg::ST_ROOT_RD:
        state_nxt = mark_q ? gdft_pkg::ST_ROOT : gdft_pkg::ST_ROOT_EMIT;
      gdft_pkg::ST_ROOT_EMIT: state_nxt = gdft_pkg::ST_TOP_RD;
      gdft_pkg::ST_TOP_RD: state_nxt = gdft_pkg::ST_NODE_RD;
      gdft_pkg::ST_NODE_RD: begin
        if (stack_q[7:0] == gdft_pkg::NIL || {1'b0, stack_q[7:0]} >= 9'(NODE_CAP)) begin
          state_nxt = (sp_r == 7'd1) ? gdft_pkg::ST_ROOT : gdft_pkg::ST_TOP_RD;
        end else begin
          state_nxt = gdft_pkg::ST_NODE_CHK;
        end
      end
      gdft_pkg::ST_NODE_CHK: state_nxt = gdft_pkg::ST_NB_EMIT;
      gdft_pkg::ST_NB_EMIT: state_nxt = gdft_pkg::ST_TOP_RD;
      gdft_pkg::ST_FLUSH: state_nxt = gdft_pkg::ST_IDLE;
      default: state_nxt = gdft_pkg::ST_IDLE;
    endcase
  end

  // nb accepted when unvisited and there is room
  assign take_nb = !mark_q && (sp_r < 7'(MAX_VERTICES)) && (nout_r < 7'(MAX_VERTICES));

  assign emit_pend = pend_r && ((state_r == gdft_pkg::ST_ROOT_EMIT) ||
                                (state_r == gdft_pkg::ST_NB_EMIT && take_nb) ||
                                (state_r == gdft_pkg::ST_FLUSH));

  // head memory: one port, read address chosen by state
  always_comb begin
    head_ra = root_r[VW-1:0];
    if (state_r == gdft_pkg::ST_IDLE) head_ra = in_vertex_a[VW-1:0];
    else if (state_r == gdft_pkg::ST_EDGE_RD) head_ra = eb_r[VW-1:0];
    else if (state_r == gdft_pkg::ST_NODE_CHK) head_ra = node_q[8+VW-1:8];
  end

  always_ff @(posedge clk) begin
    if (state_r == gdft_pkg::ST_IDLE && accept &&
        gdft_pkg::op_t'(in_op) == gdft_pkg::OP_VERTEX &&
        vcount_r < 7'(MAX_VERTICES)) begin
      label_mem[vcount_r[VW-1:0]] <= in_vertex_label;
      head_mem[vcount_r[VW-1:0]]  <= gdft_pkg::NIL;
    end else if (state_r == gdft_pkg::ST_EDGE_A) begin
      node_mem[ncount_r[NW-1:0]] <= {eb_r, head_q};
      head_mem[ea_r[VW-1:0]] <= ncount_r;
    end else if (state_r == gdft_pkg::ST_EDGE_B) begin
      node_mem[ncount_r[NW-1:0]] <= {ea_r, head_q};
      head_mem[eb_r[VW-1:0]] <= ncount_r;
    end else begin
      head_q <= head_mem[head_ra];
    end
    label_q <= label_mem[(state_r == gdft_pkg::ST_NODE_CHK) ? node_q[8+VW-1:8] : root_r[VW-1:0]];
  end

  // node memory read
  always_ff @(posedge clk) begin
    node_q <= node_mem[stack_q[NW-1:0]];
  end

  // visited marks
  always_ff @(posedge clk) begin
    if (state_r == gdft_pkg::ST_CLEAR) begin
      mark_mem[clr_r[VW-1:0]] <= 1'b0;
    end else if (state_r == gdft_pkg::ST_ROOT_RD && !mark_q) begin
      mark_mem[root_r[VW-1:0]] <= 1'b1;
    end else if (state_r == gdft_pkg::ST_NB_EMIT && take_nb) begin
      mark_mem[nb_r[VW-1:0]] <= 1'b1;
    end
    mark_q <= mark_mem[(state_r == gdft_pkg::ST_NODE_CHK) ? node_q[8+VW-1:8] : root_r[VW-1:0]];
  end

  // stack memory
  assign sp_top = VW'(sp_r - 7'd1);
  always_ff @(posedge clk) begin
    if (state_r == gdft_pkg::ST_ROOT_EMIT) begin
      stack_mem[0] <= {6'(root_r), head_q};
    end else if (state_r == gdft_pkg::ST_NODE_CHK) begin
      stack_mem[sp_top] <= {cur_v_r, node_q[7:0]};
    end else if (state_r == gdft_pkg::ST_NB_EMIT && take_nb) begin
      stack_mem[sp_r[VW-1:0]] <= {nb_r, head_q};
    end
    stack_q <= stack_mem[sp_top];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= gdft_pkg::ST_IDLE;
      vcount_r <= '0;
      ncount_r <= '0;
      root_r   <= '0;
      sp_r     <= '0;
      nout_r   <= '0;
      clr_r    <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        gdft_pkg::ST_IDLE: begin
          if (accept) begin
            ea_r <= in_vertex_a;
            eb_r <= in_vertex_b;
            if (gdft_pkg::op_t'(in_op) == gdft_pkg::OP_VERTEX && vcount_r < 7'(MAX_VERTICES))
              vcount_r <= vcount_r + 7'd1;
            clr_r  <= '0;
            root_r <= '0;
            nout_r <= '0;
            pend_r <= 1'b0;
          end
        end
        gdft_pkg::ST_EDGE_A: ncount_r <= ncount_r + 8'd1;
        gdft_pkg::ST_EDGE_B: ncount_r <= ncount_r + 8'd1;
        gdft_pkg::ST_CLEAR: clr_r <= clr_r + 7'd1;
        gdft_pkg::ST_ROOT_RD: if (mark_q) root_r <= root_r + 7'd1;
        gdft_pkg::ST_ROOT_EMIT: begin
          pend_r     <= 1'b1;
          pend_idx_r <= 6'(root_r);
          pend_lbl_r <= label_q;
          nout_r     <= nout_r + 7'd1;
          sp_r       <= 7'd1;
          cur_v_r    <= 6'(root_r);
          root_r     <= root_r + 7'd1;
        end
        gdft_pkg::ST_NODE_RD: begin
          cur_v_r <= stack_q[13:8];
          if (state_nxt != gdft_pkg::ST_NODE_CHK) sp_r <= sp_r - 7'd1;
        end
        gdft_pkg::ST_NODE_CHK: nb_r <= node_q[13:8];
        gdft_pkg::ST_NB_EMIT: begin
          if (take_nb) begin
            pend_r     <= 1'b1;
            pend_idx_r <= nb_r;
            pend_lbl_r <= label_q;
            nout_r     <= nout_r + 7'd1;
            sp_r       <= sp_r + 7'd1;
          end
        end
        gdft_pkg::ST_FLUSH: pend_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // result register, one cycle per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      ol_r <= 1'b0;
    end else begin
      ov_r <= emit_pend;
      ol_r <= emit_pend && (state_r == gdft_pkg::ST_FLUSH);
      if (emit_pend) begin
        oi_r  <= pend_idx_r;
        olb_r <= pend_lbl_r;
      end
    end
  end

  assign out_valid         = ov_r;
  assign out_last          = ol_r;
  assign out_visited_index = oi_r;
  assign out_visited_label = olb_r;

endmodule

[rtl/gdft_checker.sv]
module gdft_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_valid,
  input logic       out_last
);

  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid) else $error("last without valid");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy) else $error("busy after last");

  a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(!busy) && !busy) |-> !out_valid) else $error("result while idle");

endmodule

bind graph_depth_first_traversal gdft_checker u_gdft_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_last(out_last)
);

[tb/tb_graph_depth_first_traversal.sv]
`timescale 1ns / 1ps

module tb_graph_depth_first_traversal;

  localparam int NV = 64;
  localparam int NE = 64;
  localparam int NODES = 2 * NE;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic [5:0] idx;
    logic [7:0] lbl;
    logic       last;
  } visit_t;

  typedef struct {
    gdft_pkg::op_t op;
    logic [7:0]    lbl;
    logic [5:0]    a;
    logic [5:0]    b;
    bit            typed;
    visit_t        want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_op = gdft_pkg::OP_NONE;
  logic [7:0] in_vertex_label = '0;
  logic [5:0] in_vertex_a = '0;
  logic [5:0] in_vertex_b = '0;
  logic       out_valid;
  logic [5:0] out_visited_index;
  logic [7:0] out_visited_label;
  logic       out_last;

  graph_depth_first_traversal #(.MAX_VERTICES(NV), .MAX_EDGES(NE)) dut (.*);

  always #4 clk = ~clk;

  // graph mirror
  logic [7:0] g_labels [NV];
  logic [7:0] g_heads [NV];
  logic [5:0] g_nb [NODES];
  logic [7:0] g_next [NODES];
  int g_vcount = 0;
  int g_ncount = 0;

  visit_t visit_q[$];
  int errors = 0;
  int items = 0;
  int walks = 0;
  int visits_seen = 0;
  int idle_cycles = 0;
  bit steady = 0;

  function automatic void link_node(int owner, int nbr);
    g_nb[g_ncount] = nbr[5:0];
    g_next[g_ncount] = g_heads[owner];
    g_heads[owner] = g_ncount[7:0];
    g_ncount++;
  endfunction

  // returns the visiting order for the current graph
  function automatic void walk_graph(ref visit_t order[$]);
    bit seen [NV];
    logic [5:0] st_v [NV];
    logic [7:0] st_c [NV];
    int sp;
    int cur;
    int nb;
    visit_t vt;
    order.delete();
    foreach (seen[i]) seen[i] = 0;
    for (int root = 0; root < g_vcount; root++) begin
      if (seen[root]) continue;
      seen[root] = 1;
      vt.idx = root[5:0]; vt.lbl = g_labels[root]; vt.last = 0;
      order.push_back(vt);
      st_v[0] = root[5:0];
      st_c[0] = g_heads[root];
      sp = 1;
      while (sp > 0) begin
        cur = st_c[sp-1];
        if (cur == gdft_pkg::NIL || cur >= NODES) begin
          sp--;
          continue;
        end
        nb = g_nb[cur];
        st_c[sp-1] = g_next[cur];
        if (!seen[nb] && sp < NV && order.size() < NV) begin
          seen[nb] = 1;
          vt.idx = nb[5:0]; vt.lbl = g_labels[nb]; vt.last = 0;
          order.push_back(vt);
          st_v[sp] = nb[5:0];
          st_c[sp] = g_heads[nb];
          sp++;
        end
      end
    end
    if (order.size() > 0) order[order.size()-1].last = 1;
  endfunction

  task automatic apply_item(gdft_pkg::op_t op, logic [7:0] lbl, logic [5:0] a,
                            logic [5:0] b, ref visit_t order[$]);
    order.delete();
    case (op)
      gdft_pkg::OP_VERTEX: begin
        if (g_vcount < NV) begin
          g_labels[g_vcount] = lbl;
          g_heads[g_vcount] = gdft_pkg::NIL;
          g_vcount++;
        end
      end
      gdft_pkg::OP_EDGE: begin
        if (a < g_vcount && b < g_vcount && g_ncount + 2 <= NODES) begin
          link_node(a, b);
          link_node(b, a);
        end
      end
      gdft_pkg::OP_TRAVERSE: begin
        walk_graph(order);
        walks++;
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(gdft_pkg::op_t op, logic [7:0] lbl, logic [5:0] a, logic [5:0] b,
                      bit typed, visit_t want);
    int gap;
    visit_t order[$];
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_vertex_label <= lbl;
    in_vertex_a <= a;
    in_vertex_b <= b;
    do @(posedge clk); while (busy);
    apply_item(op, lbl, a, b, order);
    if (typed) visit_q.push_back(want);
    else foreach (order[i]) visit_q.push_back(order[i]);
    items++;
    @(negedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    visit_t w;
    if (rst_n && out_valid) begin
      visits_seen++;
      if (visit_q.size() == 0) begin
        $error("unexpected result index %0d label %0h", out_visited_index, out_visited_label);
        errors++;
      end else begin
        w = visit_q.pop_front();
        if (out_visited_index !== w.idx) begin
          $error("visited_index expected %0d got %0d", w.idx, out_visited_index);
          errors++;
        end
        if (out_visited_label !== w.lbl) begin
          $error("visited_label expected %0h got %0h", w.lbl, out_visited_label);
          errors++;
        end
        if (out_last !== w.last) begin
          $error("last expected %0b got %0b", w.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_graph_depth_first_traversal: errors");
      $finish;
    end
  end

  row_t rows[$];
  visit_t none;

  function automatic row_t mk(gdft_pkg::op_t op, logic [7:0] lbl, logic [5:0] a,
                              logic [5:0] b, bit typed = 0, logic [5:0] ei = 0,
                              logic [7:0] el = 0, logic eo = 0);
    row_t r;
    r.op = op; r.lbl = lbl; r.a = a; r.b = b; r.typed = typed;
    r.want.idx = ei; r.want.lbl = el; r.want.last = eo;
    return r;
  endfunction

  initial begin
    int r;
    gdft_pkg::op_t op;
    logic [5:0] a, b;
    none = '{idx: 0, lbl: 0, last: 0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    rows.push_back(mk(gdft_pkg::OP_TRAVERSE, 8'h00, 6'd0, 6'd0));    // empty graph
    rows.push_back(mk(gdft_pkg::OP_NONE, 8'hFF, 6'd63, 6'd63));      // unused op
    rows.push_back(mk(gdft_pkg::OP_EDGE, 8'h00, 6'd0, 6'd0));        // edge to unloaded vertex
    rows.push_back(mk(gdft_pkg::OP_VERTEX, 8'hFF, 6'd0, 6'd0));
    rows.push_back(mk(gdft_pkg::OP_TRAVERSE, 8'h00, 6'd0, 6'd0, 1, 6'd0, 8'hFF, 1'b1));
    rows.push_back(mk(gdft_pkg::OP_VERTEX, 8'h00, 6'd63, 6'd63));
    rows.push_back(mk(gdft_pkg::OP_EDGE, 8'h00, 6'd0, 6'd0));        // self loop
    rows.push_back(mk(gdft_pkg::OP_TRAVERSE, 8'h00, 6'd0, 6'd0));
    rows.push_back(mk(gdft_pkg::OP_EDGE, 8'h00, 6'd1, 6'd0));
    rows.push_back(mk(gdft_pkg::OP_EDGE, 8'h00, 6'd63, 6'd0));       // dropped
    rows.push_back(mk(gdft_pkg::OP_EDGE, 8'h00, 6'd0, 6'd63));       // dropped
    rows.push_back(mk(gdft_pkg::OP_VERTEX, 8'hAA, 6'd0, 6'd0));
    rows.push_back(mk(gdft_pkg::OP_VERTEX, 8'h55, 6'd0, 6'd0));
    rows.push_back(mk(gdft_pkg::OP_EDGE, 8'h00, 6'd2, 6'd1));
    rows.push_back(mk(gdft_pkg::OP_EDGE, 8'h00, 6'd3, 6'd0));
    rows.push_back(mk(gdft_pkg::OP_EDGE, 8'h00, 6'd3, 6'd3));
    rows.push_back(mk(gdft_pkg::OP_TRAVERSE, 8'h00, 6'd0, 6'd0));
    rows.push_back(mk(gdft_pkg::OP_NONE, 8'h00, 6'd0, 6'd0));
    foreach (rows[i])
      send(rows[i].op, rows[i].lbl, rows[i].a, rows[i].b, rows[i].typed, rows[i].want);

    for (int k = 0; k < 230; k++) begin
      if ($urandom_range(0, 19) == 0) steady = ~steady;
      r = $urandom_range(0, 99);
      if (r < 12) op = gdft_pkg::OP_TRAVERSE;
      else if (r < 15) op = gdft_pkg::OP_NONE;
      else if (r < 50) op = gdft_pkg::OP_VERTEX;
      else op = gdft_pkg::OP_EDGE;
      if ($urandom_range(0, 9) != 0 && g_vcount > 0) begin
        a = 6'($urandom_range(0, g_vcount - 1));
        b = 6'($urandom_range(0, g_vcount - 1));
      end else begin
        a = 6'($urandom);
        b = 6'($urandom);
      end
      send(op, 8'($urandom), a, b, 0, none);
    end
    send(gdft_pkg::OP_TRAVERSE, 8'h00, 6'd0, 6'd0, 0, none);
    start <= 1'b0;

    wait (visit_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("sent %0d items with %0d traversals, checked %0d visits", items, walks, visits_seen);
    $display("final graph: %0d vertices, %0d list nodes", g_vcount, g_ncount);
    if (errors == 0 && visit_q.size() == 0) begin
      $display("tb_graph_depth_first_traversal: clean");
    end else begin
      $display("tb_graph_depth_first_traversal: errors");
    end
    $finish;
  end

endmodule
